// ===== design/wall_texture_coordinate_unit_macros.svh =====
// assertion macros for the wall texture coordinate unit
// no dependencies; included by the files that check their own logic
`ifndef WALL_TEXTURE_COORDINATE_UNIT_MACROS_SVH
`define WALL_TEXTURE_COORDINATE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define WTCU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define WTCU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WTCU_ASSERT(label, clk, rst_n, prop, msg)
`define WTCU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/wtcu_pkg.sv =====
// shared constants, types and helpers of the wall texture coordinate unit
// no dependencies
package wtcu_pkg;

  localparam int WIN_H_DEF = 1024;

  localparam int SIZE_W  = 13;
  localparam int RB_W    = 16;
  localparam int BPP_W   = 4;
  localparam int ANG_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int COLH_W  = 24;
  localparam int ROWY_W  = 12;
  localparam int TXL_W   = 12;
  localparam int OFF_W   = 28;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DIF_W   = 18;
  localparam int DMAG_W  = 16;
  localparam int NUM_W   = DMAG_W + SIZE_W;
  localparam int DIV_STEPS = 13;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd3;

  localparam logic [SIZE_W-1:0] TEX_W_RST = 13'd64;
  localparam logic [SIZE_W-1:0] TEX_H_RST = 13'd64;
  localparam logic [RB_W-1:0]   RB_RST    = 16'd256;
  localparam logic [BPP_W-1:0]  BPP_RST   = 4'd4;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = 13'd4096;

  typedef struct packed {
    logic [1:0]           face;
    logic [TXL_W-1:0]     tx;
    logic                 zero;
    logic                 sat;
    logic [COLH_W-1:0]    rem;
    logic [DIV_STEPS-1:0] dvd;
    logic [DIV_STEPS-1:0] quo;
    logic [COLH_W-1:0]    dsr;
  } wtcu_div_t;

  function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end
    return r;
  endfunction

endpackage

// ===== design/wtcu_if.sv =====
// valid/ready channels of the wall texture coordinate unit
// depends on wtcu_pkg
interface wtcu_in_if
  import wtcu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hit_side;
  logic [ANG_W-1:0]  ray_angle;
  logic [FRAC_W-1:0] hit_fraction;
  logic [COLH_W-1:0] column_height;
  logic [ROWY_W-1:0] screen_row;

  modport source(output valid, hit_side, ray_angle, hit_fraction, column_height,
                 screen_row, input ready);
  modport sink(input valid, hit_side, ray_angle, hit_fraction, column_height,
               screen_row, output ready);
endinterface

interface wtcu_out_if
  import wtcu_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       face;
  logic [TXL_W-1:0] texel_x;
  logic [TXL_W-1:0] texel_y;
  logic [OFF_W-1:0] byte_offset;

  modport source(output valid, face, texel_x, texel_y, byte_offset, input ready);
  modport sink(input valid, face, texel_x, texel_y, byte_offset, output ready);
endinterface

// ===== design/wall_texture_coordinate_unit.sv =====
// Wall texture coordinate unit, top level.
// One word on in_ch per screen pixel of a wall column (hit side, ray angle,
// hit fraction, column height, screen row); one word on out_ch per input word
// with face, texel column, texel row and byte offset, in the same order.
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput is one word per clock while out_ch does not stall. A word passes
// from acceptance to out_ch.valid through three front stages, a chain of 13
// divide cells that settle one bit of the texel row each, and three back
// stages ending in the output register. The divide chain sets the depth.
// The cfg port writes texture width, height, row stride and bytes per texel;
// write it only while no word is in flight.
// Reset empties the pipeline and restores the default texture format.
// When out_ch stalls, each stage holds its word and empty stages keep
// filling; in_ch.ready drops only once all 19 stages hold a word.
// depends on wtcu_pkg, wtcu_if, wtcu_front, wtcu_div_cell, wtcu_back
`include "wall_texture_coordinate_unit_macros.svh"
module wall_texture_coordinate_unit
  import wtcu_pkg::*;
#(
  parameter int WINDOW_HEIGHT = WIN_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wtcu_in_if.sink              in_ch,
  wtcu_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [SIZE_W-1:0] tex_w_r;
  logic [SIZE_W-1:0] tex_h_r;
  logic [RB_W-1:0]   row_bytes_r;
  logic [BPP_W-1:0]  bpp_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  logic      div_v   [DIV_STEPS+1];
  logic      div_rdy [DIV_STEPS+1];
  wtcu_div_t div_d   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r     <= TEX_W_RST;
      tex_h_r     <= TEX_H_RST;
      row_bytes_r <= RB_RST;
      bpp_r       <= BPP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TEX_WIDTH:  tex_w_r     <= cfg_wdata[SIZE_W-1:0];
        CFG_TEX_HEIGHT: tex_h_r     <= cfg_wdata[SIZE_W-1:0];
        CFG_ROW_BYTES:  row_bytes_r <= cfg_wdata[RB_W-1:0];
        CFG_BPP:        bpp_r       <= cfg_wdata[BPP_W-1:0];
        default:        tex_w_r     <= tex_w_r;
      endcase
    end
  end

  assign w_eff = limit_size(tex_w_r);
  assign h_eff = limit_size(tex_h_r);

  wtcu_front #(
    .WINDOW_HEIGHT(WINDOW_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .tex_w    (w_eff),
    .tex_h    (h_eff),
    .out_valid(div_v[0]),
    .out_ready(div_rdy[0]),
    .out_data (div_d[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    wtcu_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (div_v[k]),
      .in_ready (div_rdy[k]),
      .in_data  (div_d[k]),
      .out_valid(div_v[k+1]),
      .out_ready(div_rdy[k+1]),
      .out_data (div_d[k+1])
    );
  end

  wtcu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_v[DIV_STEPS]),
    .in_ready (div_rdy[DIV_STEPS]),
    .in_data  (div_d[DIV_STEPS]),
    .tex_h    (h_eff),
    .row_bytes(row_bytes_r),
    .bpp      (bpp_r),
    .out_ch   (out_ch)
  );

  `WTCU_ASSERT(a_stall_only_when_full, clk, rst_n, !in_ch.ready |-> (out_ch.valid && !out_ch.ready), "input stalled while the output was moving")

endmodule

// ===== design/wtcu_front.sv =====
// front stages: face pick, texture column, wall top and divider setup
// depends on wtcu_pkg and wtcu_in_if
module wtcu_front
  import wtcu_pkg::*;
#(
  parameter int WINDOW_HEIGHT = WIN_H_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wtcu_in_if.sink           in_ch,
  input  logic [SIZE_W-1:0] tex_w,
  input  logic [SIZE_W-1:0] tex_h,
  output logic              out_valid,
  input  logic              out_ready,
  output wtcu_div_t         out_data
);

  localparam logic signed [COLH_W+1:0] WIN_FIX = (COLH_W+2)'(WINDOW_HEIGHT * 256);

  // stage 1
  logic                     v1_r;
  logic [1:0]               face1_r;
  logic [SIZE_W-1:0]        txp1_r;
  logic signed [DIF_W-1:0]  d1_r;
  logic [COLH_W-1:0]        colh1_r;
  // stage 2
  logic                     v2_r;
  logic [1:0]               face2_r;
  logic [TXL_W-1:0]         tx2_r;
  logic [NUM_W-1:0]         n2_r;
  logic                     zero2_r;
  logic [COLH_W-1:0]        colh2_r;
  // stage 3
  logic                     v3_r;
  wtcu_div_t                div3_r;

  logic rdy1, rdy2, rdy3;

  logic [1:0]                  face_nxt;
  logic [FRAC_W+SIZE_W-1:0]    txp_full;
  logic [COLH_W-1:0]           colh_eff;
  logic signed [COLH_W+1:0]    diff;
  logic signed [COLH_W+1:0]    adj;
  logic signed [DIF_W-2:0]     top;
  logic signed [DIF_W-1:0]     d_nxt;
  logic [SIZE_W-1:0]           tx13;
  logic [SIZE_W-1:0]           txm;
  logic [DMAG_W-1:0]           dmag;
  logic [NUM_W-1:0]            n_nxt;
  wtcu_div_t                   div_nxt;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    if (in_ch.hit_side) begin
      face_nxt = (in_ch.ray_angle > 16'd32768) ? FACE_NORTH : FACE_SOUTH;
    end else if (in_ch.ray_angle > 16'd16384 && in_ch.ray_angle <= 16'd49152) begin
      face_nxt = FACE_EAST;
    end else begin
      face_nxt = FACE_WEST;
    end
    txp_full = (FRAC_W+SIZE_W)'(in_ch.hit_fraction) * (FRAC_W+SIZE_W)'(tex_w);
    colh_eff = (in_ch.column_height == '0) ? 24'd1 : in_ch.column_height;
    diff = WIN_FIX - $signed({2'b00, colh_eff});
    // truncate toward zero
    adj = diff[COLH_W+1] ? (diff + 26'sd511) : diff;
    top = adj[COLH_W+1:9];
    d_nxt = $signed({6'b000000, in_ch.screen_row}) - $signed({top[DIF_W-2], top});
  end

  always_comb begin
    tx13 = (txp1_r >= tex_w) ? (tex_w - 13'd1) : txp1_r;
    txm = (face1_r == FACE_NORTH || face1_r == FACE_EAST) ? (tex_w - 13'd1 - tx13) : tx13;
    dmag = d1_r[DIF_W-1] ? '0 : d1_r[DMAG_W-1:0];
    n_nxt = NUM_W'(dmag) * NUM_W'(tex_h);
  end

  always_comb begin
    div_nxt.face = face2_r;
    div_nxt.tx   = tx2_r;
    div_nxt.zero = zero2_r;
    div_nxt.rem  = n2_r[NUM_W-1:5];
    div_nxt.sat  = n2_r[NUM_W-1:5] >= colh2_r;
    div_nxt.dvd  = {n2_r[4:0], 8'h00};
    div_nxt.quo  = '0;
    div_nxt.dsr  = colh2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      face1_r <= face_nxt;
      txp1_r  <= txp_full[FRAC_W+SIZE_W-1:FRAC_W];
      d1_r    <= d_nxt;
      colh1_r <= colh_eff;
    end
    if (rdy2 && v1_r) begin
      face2_r <= face1_r;
      tx2_r   <= txm[TXL_W-1:0];
      n2_r    <= n_nxt;
      zero2_r <= d1_r[DIF_W-1];
      colh2_r <= colh1_r;
    end
    if (rdy3 && v2_r) begin
      div3_r <= div_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = div3_r;

endmodule

// ===== design/wtcu_div_cell.sv =====
// one restoring divide cell: settles one quotient bit per stage
// depends on wtcu_pkg and the assertion macros
`include "wall_texture_coordinate_unit_macros.svh"
module wtcu_div_cell
  import wtcu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wtcu_div_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output wtcu_div_t out_data
);

  logic        v_r;
  wtcu_div_t   d_r;
  wtcu_div_t   d_nxt;
  logic [COLH_W:0] trial;
  logic [COLH_W:0] sub;
  logic        ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    trial = {in_data.rem, in_data.dvd[DIV_STEPS-1]};
    sub   = trial - {1'b0, in_data.dsr};
    ge    = trial >= {1'b0, in_data.dsr};
    d_nxt = in_data;
    d_nxt.rem = ge ? sub[COLH_W-1:0] : trial[COLH_W-1:0];
    d_nxt.dvd = {in_data.dvd[DIV_STEPS-2:0], 1'b0};
    d_nxt.quo = {in_data.quo[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

  `WTCU_ASSERT(a_rem_below_divisor, clk, rst_n, (in_valid && in_ready && !in_data.sat && !in_data.zero && (in_data.rem < in_data.dsr)) |=> (out_data.rem < out_data.dsr), "partial remainder reached the divisor")
  `WTCU_ASSERT(a_cell_holds, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled cell lost its word")

endmodule

// ===== design/wtcu_back.sv =====
// back stages: texture row clamp, offset products and output register
// depends on wtcu_pkg, wtcu_out_if and the assertion macros
`include "wall_texture_coordinate_unit_macros.svh"
module wtcu_back
  import wtcu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wtcu_div_t         in_data,
  input  logic [SIZE_W-1:0] tex_h,
  input  logic [RB_W-1:0]   row_bytes,
  input  logic [BPP_W-1:0]  bpp,
  wtcu_out_if.source        out_ch
);

  logic             v4_r;
  logic [1:0]       face4_r;
  logic [TXL_W-1:0] tx4_r;
  logic [TXL_W-1:0] ty4_r;

  logic             v5_r;
  logic [1:0]       face5_r;
  logic [TXL_W-1:0] tx5_r;
  logic [TXL_W-1:0] ty5_r;
  logic [OFF_W-1:0] pry5_r;
  logic [RB_W-1:0]  prx5_r;

  logic             ov_r;
  logic [1:0]       face6_r;
  logic [TXL_W-1:0] tx6_r;
  logic [TXL_W-1:0] ty6_r;
  logic [OFF_W-1:0] off6_r;

  logic rdy4, rdy5, rdy6;
  logic [SIZE_W-1:0] ty_full;

  assign rdy6 = !ov_r || out_ch.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_comb begin
    if (in_data.zero) begin
      ty_full = '0;
    end else if (in_data.sat || in_data.quo >= tex_h) begin
      ty_full = tex_h - 13'd1;
    end else begin
      ty_full = in_data.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= in_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        ov_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      face4_r <= in_data.face;
      tx4_r   <= in_data.tx;
      ty4_r   <= ty_full[TXL_W-1:0];
    end
    if (rdy5 && v4_r) begin
      face5_r <= face4_r;
      tx5_r   <= tx4_r;
      ty5_r   <= ty4_r;
      pry5_r  <= OFF_W'(ty4_r) * OFF_W'(row_bytes);
      prx5_r  <= RB_W'(tx4_r) * RB_W'(bpp);
    end
    if (rdy6 && v5_r) begin
      face6_r <= face5_r;
      tx6_r   <= tx5_r;
      ty6_r   <= ty5_r;
      off6_r  <= pry5_r + OFF_W'(prx5_r);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.face        = face6_r;
  assign out_ch.texel_x     = tx6_r;
  assign out_ch.texel_y     = ty6_r;
  assign out_ch.byte_offset = off6_r;

  `WTCU_ASSERT(a_above_top_row_zero, clk, rst_n, (in_valid && in_ready && in_data.zero) |=> (ty4_r == '0), "pixel above the wall top got a nonzero row")
  `WTCU_ASSERT_ALWAYS(a_reset_empties_output, clk, !rst_n |=> !out_ch.valid, "output word valid right after reset")

endmodule

// ===== sim/wall_texture_coordinate_unit_tb.sv =====
// testbench for wall_texture_coordinate_unit: directed and random pixel words,
// each result checked against a texel mapping predictor kept in the bench
// depends on wtcu_pkg, wtcu_if and the wall_texture_coordinate_unit rtl
module wall_texture_coordinate_unit_tb;
  import wtcu_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic              hit_side;
    logic [ANG_W-1:0]  ray_angle;
    logic [FRAC_W-1:0] hit_fraction;
    logic [COLH_W-1:0] column_height;
    logic [ROWY_W-1:0] screen_row;
  } pixel_t;

  typedef struct packed {
    logic [1:0]       face;
    logic [TXL_W-1:0] texel_x;
    logic [TXL_W-1:0] texel_y;
    logic [OFF_W-1:0] byte_offset;
  } texel_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  wtcu_in_if  in_ch ();
  wtcu_out_if out_ch ();

  logic [SIZE_W-1:0] fmt_width = TEX_W_RST;
  logic [SIZE_W-1:0] fmt_height = TEX_H_RST;
  logic [RB_W-1:0]   fmt_row_bytes = RB_RST;
  logic [BPP_W-1:0]  fmt_bpp = BPP_RST;

  texel_t      expected_texels[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          holds_requested = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  wall_texture_coordinate_unit #(
    .WINDOW_HEIGHT(WIN_H_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic texel_t map_texel(pixel_t p);
    texel_t t;
    longint w;
    longint h;
    longint colh;
    longint wall_top;
    longint q;
    longint tx;
    longint ty;
    longint off;
    w = fmt_width;
    if (w == 0) begin
      w = 1;
    end else if (w > longint'(SIZE_MAX)) begin
      w = SIZE_MAX;
    end
    h = fmt_height;
    if (h == 0) begin
      h = 1;
    end else if (h > longint'(SIZE_MAX)) begin
      h = SIZE_MAX;
    end
    if (p.hit_side) begin
      t.face = (p.ray_angle > 16'd32768) ? FACE_NORTH : FACE_SOUTH;
    end else if (p.ray_angle > 16'd16384 && p.ray_angle <= 16'd49152) begin
      t.face = FACE_EAST;
    end else begin
      t.face = FACE_WEST;
    end
    tx = (longint'(p.hit_fraction) * w) >> 16;
    if (tx >= w) begin
      tx = w - 1;
    end
    if (t.face == FACE_NORTH || t.face == FACE_EAST) begin
      tx = w - 1 - tx;
    end
    colh = p.column_height;
    if (colh == 0) begin
      colh = 1;
    end
    wall_top = (longint'(WIN_H_DEF) * 256 - colh) / 512;
    q = (longint'(p.screen_row) - wall_top) * h * 256 / colh;
    if (q < 0) begin
      ty = 0;
    end else if (q >= h) begin
      ty = h - 1;
    end else begin
      ty = q;
    end
    off = ty * longint'(fmt_row_bytes) + tx * longint'(fmt_bpp);
    t.texel_x = TXL_W'(tx);
    t.texel_y = TXL_W'(ty);
    t.byte_offset = OFF_W'(off);
    return t;
  endfunction

  function automatic pixel_t make_pixel(logic side, int unsigned ang, int unsigned frac,
                                        int unsigned colh, int unsigned row);
    pixel_t p;
    p.hit_side = side;
    p.ray_angle = ANG_W'(ang);
    p.hit_fraction = FRAC_W'(frac);
    p.column_height = COLH_W'(colh);
    p.screen_row = ROWY_W'(row);
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    longint colh;
    longint wall_top;
    longint row;
    p.hit_side = 1'($urandom_range(1));
    if ($urandom_range(7) == 0) begin
      // near a face boundary
      p.ray_angle = ANG_W'(16384 * $urandom_range(4) + $urandom_range(2) - 1);
    end else begin
      p.ray_angle = ANG_W'($urandom_range(16'hFFFF));
    end
    case ($urandom_range(7))
      0: p.hit_fraction = '0;
      1: p.hit_fraction = '1;
      default: p.hit_fraction = FRAC_W'($urandom_range(16'hFFFF));
    endcase
    case ($urandom_range(7))
      0: colh = $urandom_range(24'hFFFFFF);
      1: colh = $urandom_range(255);
      default: colh = $urandom_range(1 << 19, 256);
    endcase
    p.column_height = COLH_W'(colh);
    if ($urandom_range(1)) begin
      row = $urandom_range(4095);
    end else begin
      // row within the visible wall span
      wall_top = (longint'(WIN_H_DEF) * 256 - ((colh == 0) ? 1 : colh)) / 512;
      row = wall_top + longint'($urandom_range(32'(colh >> 8) + 1));
      if (row < 0) begin
        row = 0;
      end else if (row > 4095) begin
        row = 4095;
      end
    end
    p.screen_row = ROWY_W'(row);
    return p;
  endfunction

  task automatic check_field(string label, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, actual %0d", label, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin : result_check
    texel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_texels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word with nothing expected: face %0d x %0d y %0d offset %0d",
                   out_ch.face, out_ch.texel_x, out_ch.texel_y, out_ch.byte_offset);
        end
      end else begin
        want = expected_texels.pop_front();
        check_field("face", want.face, out_ch.face);
        check_field("texel_x", want.texel_x, out_ch.texel_x);
        check_field("texel_y", want.texel_y, out_ch.texel_y);
        check_field("byte_offset", want.byte_offset, out_ch.byte_offset);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.hit_side <= p.hit_side;
    in_ch.ray_angle <= p.ray_angle;
    in_ch.hit_fraction <= p.hit_fraction;
    in_ch.column_height <= p.column_height;
    in_ch.screen_row <= p.screen_row;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_texels.push_back(map_texel(p));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_texels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_TEX_WIDTH: fmt_width = data[SIZE_W-1:0];
      CFG_TEX_HEIGHT: fmt_height = data[SIZE_W-1:0];
      CFG_ROW_BYTES: fmt_row_bytes = data[RB_W-1:0];
      CFG_BPP: fmt_bpp = data[BPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_format(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                logic [CFG_W-1:0] rb, logic [CFG_W-1:0] bpp);
    put_reg(CFG_TEX_WIDTH, w);
    put_reg(CFG_TEX_HEIGHT, h);
    put_reg(CFG_ROW_BYTES, rb);
    put_reg(CFG_BPP, bpp);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] random_size();
    case ($urandom_range(3))
      0: return CFG_W'(1 << $urandom_range(12));
      1: return CFG_W'($urandom_range(4096, 1));
      2: return CFG_W'($urandom_range(16'hFFFF));
      default: return CFG_W'($urandom_range(256, 1));
    endcase
  endfunction

  task automatic program_random_format();
    program_format(random_size(), random_size(), CFG_W'($urandom_range(16'hFFFF)),
                   CFG_W'($urandom_range(15)));
  endtask

  task automatic test_face_select();
    send_pixel(make_pixel(1'b1, 0, 16'h4000, 24'h040000, 0));
    send_pixel(make_pixel(1'b1, 32768, 16'h4000, 24'h040000, 100));
    send_pixel(make_pixel(1'b1, 32769, 16'h4000, 24'h040000, 200));
    send_pixel(make_pixel(1'b1, 65535, 16'h4000, 24'h040000, 300));
    send_pixel(make_pixel(1'b0, 16384, 16'h4000, 24'h040000, 400));
    send_pixel(make_pixel(1'b0, 16385, 16'h4000, 24'h040000, 500));
    send_pixel(make_pixel(1'b0, 49152, 16'h4000, 24'h040000, 600));
    send_pixel(make_pixel(1'b0, 49153, 16'h4000, 24'h040000, 1023));
  endtask

  task automatic test_field_extremes();
    send_pixel(make_pixel(1'b1, 40000, 0, 24'h040000, 0));
    send_pixel(make_pixel(1'b0, 20000, 16'hFFFF, 24'h040000, 4095));
    send_pixel(make_pixel(1'b0, 0, 16'hFFFF, 24'h040000, 512));
    // zero column height
    send_pixel(make_pixel(1'b1, 0, 0, 0, 0));
    send_pixel(make_pixel(1'b1, 0, 1234, 1, 512));
    // wall taller than the window
    send_pixel(make_pixel(1'b0, 60000, 16'h8000, 24'hFFFFFF, 0));
    send_pixel(make_pixel(1'b0, 60000, 16'h8000, 24'hFFFFFF, 4095));
    send_pixel(make_pixel(1'b1, 50000, 16'hFFFF, 24'h000100, 512));
  endtask

  task automatic send_size_probe();
    send_pixel(make_pixel(1'b1, 40000, 16'hFFFF, 24'h040000, 1023));
    send_pixel(make_pixel(1'b0, 0, 0, 24'h040000, 0));
    send_pixel(make_pixel(1'b0, 30000, 16'h8000, 24'h010000, 520));
  endtask

  task automatic test_size_limits();
    wait_drained();
    program_format('0, '0, '0, '0);
    send_size_probe();
    wait_drained();
    program_format(16'hFFFF, 16'd4097, 16'hFFFF, 16'hFFFF);
    send_size_probe();
    wait_drained();
    program_format(16'd4096, 16'h2000, 16'd1, 16'd8);
    send_size_probe();
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct, int n);
    wait_drained();
    program_random_format();
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        wait_drained();
      end
      send_pixel(random_pixel());
    end
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    wait_drained();
    program_random_format();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    holds_requested++;
    for (int i = 0; i < 100; i++) begin
      send_pixel(random_pixel());
    end
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_TEX_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.hit_side <= 1'b0;
    in_ch.ray_angle <= '0;
    in_ch.hit_fraction <= '0;
    in_ch.column_height <= '0;
    in_ch.screen_row <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_face_select();
    test_field_extremes();
    test_size_limits();
    test_random_traffic(30, 48, 500);
    test_random_traffic(48, 30, 500);
    test_random_traffic(0, 0, 500);
    test_output_holdoff();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== wall_texture_coordinate_unit.f =====
+incdir+design
design/wtcu_pkg.sv
design/wtcu_if.sv
design/wtcu_front.sv
design/wtcu_div_cell.sv
design/wtcu_back.sv
design/wall_texture_coordinate_unit.sv
sim/wall_texture_coordinate_unit_tb.sv
